// ===== rtl/wsr_pkg.sv =====
// Shared types and constants of the WebSocket frame receiver.
`default_nettype none

package wsr_pkg;

  // Byte classification codes carried on tuser
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_BINARY  = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Reply request codes
  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_PONG  = 2'd1;
  localparam logic [1:0] REPLY_CLOSE = 2'd2;

  // Frame opcodes
  localparam logic [3:0] OP_CONT    = 4'h0;
  localparam logic [3:0] OP_BINARY  = 4'h2;
  localparam logic [3:0] OP_CONTROL = 4'h8;
  localparam logic [3:0] OP_CLOSE   = 4'h8;
  localparam logic [3:0] OP_PING    = 4'h9;

  // 7-bit length code that announces extended length bytes
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // Extended length byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Width of the output tdata bus
  localparam int unsigned OUT_DATA_W = 16;

  // Result of one received byte
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [3:0] effective_opcode;
    logic       frame_end;
    logic [1:0] reply;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/websocket_frame_receiver.sv =====
// Top level of the WebSocket frame receiver: input and result registers.
//
// Usage:
//   s_axis carries the received byte stream, one byte per transaction.
//   m_axis gives one transaction per byte: the byte, its effective opcode and
//   any reply request in tdata, its classification in tuser (header, binary
//   data, reply payload, discarded, error), and tlast on the byte that ends a
//   frame. A masked frame puts the receiver into a sticky error until reset.
// Path: an accepted byte is held in the input register and moves to the result
//   register, which offers it on m_axis, once that register is empty or taken.
// Throughput: one byte per cycle while m_axis_tready stays high; the header/payload
//   update is a single combinational pass between the input register and the result register.
// Reset: rst clears both registers and the parser, which then expects the
//   opcode byte of a new frame.
// Stall: while m_axis_tready is low a result is held; one more byte waits in
//   the input register, and s_axis_tready drops once both are full.
`default_nettype none

module websocket_frame_receiver (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [7:0]                       s_axis_tdata,   // [7:0] in_byte
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [wsr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] out_byte,
                                                           // [11:8] effective_opcode,
                                                           // [13:12] reply, [15:14] zero
  output logic                             m_axis_tlast,   // frame_end
  output logic [2:0]                       m_axis_tuser    // kind
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              advance;
  wsr_pkg::result_t  step_res;
  wsr_pkg::result_t  out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  wsr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .result  (step_res)
  );

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.reply, out_res.effective_opcode, out_res.out_byte};
  assign m_axis_tlast = out_res.frame_end;
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== rtl/wsr_parser.sv =====
// Frame header parser and byte classifier; holds the per-connection state.
`default_nettype none

module wsr_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   advance,
  input  wire  [7:0]            in_byte,
  output wsr_pkg::result_t      result
);

  typedef enum logic [2:0] {
    PH_OPCODE   = 3'd0,
    PH_LENMASK  = 3'd1,
    PH_SHORTLEN = 3'd2,
    PH_LONGLEN  = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_ERROR    = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [3:0]  fragment_opcode, fragment_opcode_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [3:0]  length_bytes_seen, length_bytes_seen_next;
  logic        mask_flag, mask_flag_next;
  logic        had_payload, had_payload_next;
  logic        close_sent, close_sent_next;

  logic        header_end;
  logic        do_end;
  logic [3:0]  cur_eff;
  logic [3:0]  need;
  logic [1:0]  end_reply;

  assign cur_eff = (frame_opcode == wsr_pkg::OP_CONT) ? fragment_opcode : frame_opcode;

  // Compute next state and the result for the byte in hand
  always_comb begin
    phase_next             = phase;
    frame_opcode_next      = frame_opcode;
    fragment_opcode_next   = fragment_opcode;
    remaining_length_next  = remaining_length;
    length_bytes_seen_next = length_bytes_seen;
    mask_flag_next         = mask_flag;
    had_payload_next       = had_payload;
    close_sent_next        = close_sent;
    header_end             = 1'b0;
    do_end                 = 1'b0;
    end_reply              = wsr_pkg::REPLY_NONE;
    need                   = (phase == PH_SHORTLEN) ? wsr_pkg::EXT16_BYTES
                                                    : wsr_pkg::EXT64_BYTES;
    result.kind             = wsr_pkg::KIND_HEADER;
    result.out_byte         = in_byte;
    result.frame_end        = 1'b0;
    result.reply            = wsr_pkg::REPLY_NONE;
    result.effective_opcode = 4'h0;

    case (phase)
      PH_OPCODE: begin
        frame_opcode_next = in_byte[3:0];
        if (in_byte[3:0] != wsr_pkg::OP_CONT && in_byte[3:0] < wsr_pkg::OP_CONTROL) begin
          fragment_opcode_next = in_byte[3:0];
        end
        had_payload_next = 1'b0;
        phase_next       = PH_LENMASK;
      end
      PH_LENMASK: begin
        mask_flag_next         = in_byte[7];
        length_bytes_seen_next = 4'd0;
        remaining_length_next  = 64'd0;
        if (in_byte[6:0] < wsr_pkg::LEN_EXT16) begin
          remaining_length_next = {57'd0, in_byte[6:0]};
          header_end            = 1'b1;
        end else if (in_byte[6:0] == wsr_pkg::LEN_EXT16) begin
          phase_next = PH_SHORTLEN;
        end else begin
          phase_next = PH_LONGLEN;
        end
      end
      PH_SHORTLEN, PH_LONGLEN: begin
        remaining_length_next  = {remaining_length[55:0], in_byte};
        length_bytes_seen_next = length_bytes_seen + 4'd1;
        if (length_bytes_seen_next >= need) begin
          header_end = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (cur_eff == wsr_pkg::OP_BINARY) begin
          result.kind = wsr_pkg::KIND_BINARY;
        end else if (cur_eff == wsr_pkg::OP_CLOSE || cur_eff == wsr_pkg::OP_PING) begin
          result.kind = wsr_pkg::KIND_REPLY;
        end else begin
          result.kind = wsr_pkg::KIND_DISCARD;
        end
        if (cur_eff == wsr_pkg::OP_PING) begin
          had_payload_next = 1'b1;
        end
        remaining_length_next = remaining_length - 64'd1;
        if (remaining_length_next == 64'd0) begin
          do_end     = 1'b1;
          phase_next = PH_OPCODE;
        end
      end
      default: begin
        phase_next  = PH_ERROR;
        result.kind = wsr_pkg::KIND_ERROR;
      end
    endcase

    // Close out the header: masked frame, empty frame or payload
    if (header_end) begin
      if (mask_flag_next) begin
        phase_next  = PH_ERROR;
        result.kind = wsr_pkg::KIND_ERROR;
      end else if (remaining_length_next == 64'd0) begin
        do_end     = 1'b1;
        phase_next = PH_OPCODE;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    result.effective_opcode = (frame_opcode_next == wsr_pkg::OP_CONT) ? fragment_opcode_next
                                                                      : frame_opcode_next;

    // Request a reply at frame end; frame opcode is unchanged in these phases
    if (do_end) begin
      if (cur_eff == wsr_pkg::OP_PING) begin
        if (!close_sent) begin
          if (had_payload_next) begin
            end_reply = wsr_pkg::REPLY_PONG;
          end else begin
            end_reply       = wsr_pkg::REPLY_CLOSE;
            close_sent_next = 1'b1;
          end
        end
      end else if (cur_eff == wsr_pkg::OP_CLOSE) begin
        if (!close_sent) begin
          end_reply = wsr_pkg::REPLY_CLOSE;
        end
        close_sent_next = 1'b1;
      end
      had_payload_next = 1'b0;
      result.frame_end = 1'b1;
      result.reply     = end_reply;
    end
  end

  // Hold state; advance once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_OPCODE;
      frame_opcode      <= 4'h0;
      fragment_opcode   <= 4'h0;
      remaining_length  <= 64'd0;
      length_bytes_seen <= 4'd0;
      mask_flag         <= 1'b0;
      had_payload       <= 1'b0;
      close_sent        <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      frame_opcode      <= frame_opcode_next;
      fragment_opcode   <= fragment_opcode_next;
      remaining_length  <= remaining_length_next;
      length_bytes_seen <= length_bytes_seen_next;
      mask_flag         <= mask_flag_next;
      had_payload       <= had_payload_next;
      close_sent        <= close_sent_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the WebSocket frame receiver.
`timescale 1ns / 1ps

module tb_top;

  // Opcodes and length codes not given by the package
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Length encodings of a frame header
  localparam int ENC_DIRECT = 0;
  localparam int ENC_EXT16  = 1;
  localparam int ENC_EXT64  = 2;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    RX_OPCODE, RX_LENMASK, RX_EXT16, RX_EXT64, RX_PAYLOAD, RX_ERROR
  } rx_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [11:8] effective_opcode,
                                       // [13:12] reply, [15:14] zero
  logic        m_axis_tlast;           // frame_end
  logic [2:0]  m_axis_tuser;           // kind

  websocket_frame_receiver uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Idling percentages of the byte source and the result sink
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Predicted parser state
  rx_phase_t   rx_phase = RX_OPCODE;
  logic [3:0]  cur_opcode = '0;
  logic [3:0]  msg_opcode = '0;
  logic [63:0] bytes_left = '0;
  logic [3:0]  ext_seen = '0;
  logic        frame_masked = 1'b0;
  logic        ping_had_data = 1'b0;
  logic        close_requested = 1'b0;

  // Classifications still owed by the receiver, oldest first
  wsr_pkg::result_t pending_results[$];
  wsr_pkg::result_t want;

  function automatic logic [3:0] effective_op();
    return (cur_opcode == wsr_pkg::OP_CONT) ? msg_opcode : cur_opcode;
  endfunction

  // Reply owed at the end of a frame; clears the ping payload mark
  function automatic logic [1:0] frame_end_reply(input logic [3:0] e);
    logic [1:0] r;
    r = wsr_pkg::REPLY_NONE;
    if (e == wsr_pkg::OP_PING) begin
      if (!close_requested) begin
        if (ping_had_data) begin
          r = wsr_pkg::REPLY_PONG;
        end else begin
          r = wsr_pkg::REPLY_CLOSE;
          close_requested = 1'b1;
        end
      end
    end else if (e == wsr_pkg::OP_CLOSE) begin
      if (!close_requested) r = wsr_pkg::REPLY_CLOSE;
      close_requested = 1'b1;
    end
    ping_had_data = 1'b0;
    return r;
  endfunction

  // Header complete: go to error, close an empty frame, or expect payload
  function automatic void finish_header(inout wsr_pkg::result_t r);
    if (frame_masked) begin
      rx_phase = RX_ERROR;
      r.kind = wsr_pkg::KIND_ERROR;
    end else if (bytes_left == 64'd0) begin
      r.frame_end = 1'b1;
      r.reply = frame_end_reply(effective_op());
      rx_phase = RX_OPCODE;
    end else begin
      rx_phase = RX_PAYLOAD;
    end
  endfunction

  // Classify one received byte and advance the predicted parser
  function automatic wsr_pkg::result_t classify_byte(input logic [7:0] b);
    wsr_pkg::result_t r;
    logic [3:0] e;
    logic [3:0] need;
    r = '0;
    r.kind = wsr_pkg::KIND_HEADER;
    r.out_byte = b;
    case (rx_phase)
      RX_OPCODE: begin
        cur_opcode = b[3:0];
        if (cur_opcode != wsr_pkg::OP_CONT && cur_opcode < wsr_pkg::OP_CONTROL)
          msg_opcode = cur_opcode;
        ping_had_data = 1'b0;
        rx_phase = RX_LENMASK;
      end
      RX_LENMASK: begin
        frame_masked = b[7];
        ext_seen = '0;
        bytes_left = '0;
        if (b[6:0] < wsr_pkg::LEN_EXT16) begin
          bytes_left = {57'd0, b[6:0]};
          finish_header(r);
        end else if (b[6:0] == wsr_pkg::LEN_EXT16) begin
          rx_phase = RX_EXT16;
        end else begin
          rx_phase = RX_EXT64;
        end
      end
      RX_EXT16, RX_EXT64: begin
        need = (rx_phase == RX_EXT16) ? wsr_pkg::EXT16_BYTES : wsr_pkg::EXT64_BYTES;
        bytes_left = {bytes_left[55:0], b};
        ext_seen = ext_seen + 4'd1;
        if (ext_seen >= need) finish_header(r);
      end
      RX_PAYLOAD: begin
        e = effective_op();
        if (e == wsr_pkg::OP_BINARY) r.kind = wsr_pkg::KIND_BINARY;
        else if (e == wsr_pkg::OP_CLOSE || e == wsr_pkg::OP_PING) r.kind = wsr_pkg::KIND_REPLY;
        else r.kind = wsr_pkg::KIND_DISCARD;
        if (e == wsr_pkg::OP_PING) ping_had_data = 1'b1;
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 64'd0) begin
          r.frame_end = 1'b1;
          r.reply = frame_end_reply(e);
          rx_phase = RX_OPCODE;
        end
      end
      default: begin
        rx_phase = RX_ERROR;
        r.kind = wsr_pkg::KIND_ERROR;
      end
    endcase
    r.effective_opcode = effective_op();
    return r;
  endfunction

  // Offer one byte, hold it until the transaction, record its classification
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(classify_byte(b));
    bytes_sent++;
  endtask

  // Send a whole frame; a masked frame stops after its header
  task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                            input int enc, input logic mask);
    logic [63:0] i;
    send_byte({4'($urandom_range(15)), op});
    case (enc)
      ENC_EXT16: begin
        send_byte({mask, wsr_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      ENC_EXT64: begin
        send_byte({mask, LEN_EXT64});
        for (int k = 7; k >= 0; k--) send_byte(len[k*8 +: 8]);
      end
      default: send_byte({mask, len[6:0]});
    endcase
    if (!mask) begin
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Random well-formed frames until about n_bytes have been sent
  task automatic random_frames(input int unsigned n_bytes, input bit allow_close);
    int unsigned start_count;
    int unsigned pick;
    logic [3:0]  op;
    logic [63:0] len;
    int          enc;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 35) op = wsr_pkg::OP_BINARY;
      else if (pick < 50) op = wsr_pkg::OP_CONT;
      else if (pick < 60) op = OP_TEXT;
      else if (pick < 72) op = wsr_pkg::OP_PING;
      else if (pick < 80) op = OP_PONG;
      else if (pick < 88) op = 4'($urandom_range(3, 7));
      else if (pick < 94) op = 4'($urandom_range(11, 15));
      else op = allow_close ? wsr_pkg::OP_CLOSE : wsr_pkg::OP_BINARY;

      pick = $urandom_range(99);
      enc = ENC_DIRECT;
      if (pick < 15) begin
        len = 64'd0;
      end else if (pick < 70) begin
        len = 64'($urandom_range(1, 20));
      end else if (pick < 85) begin
        len = 64'($urandom_range(21, 125));
      end else if (pick < 95) begin
        enc = ENC_EXT16;
        len = 64'($urandom_range(0, 300));
      end else begin
        enc = ENC_EXT64;
        len = 64'($urandom_range(0, 40));
      end
      // Keep an empty ping from ending the session while closes are held back
      if (!allow_close && op == wsr_pkg::OP_PING && len == 64'd0) len = 64'd1;
      send_frame(op, len, enc, 1'b0);
    end
  endtask

  // Extreme bytes, each length encoding, fragmentation and a pong request
  task automatic test_directed_frames();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_frame(wsr_pkg::OP_CONT, 64'd1, ENC_DIRECT, 1'b0);  // continuation with no message open
    send_byte({4'hF, wsr_pkg::OP_BINARY});
    send_byte({1'b0, wsr_pkg::LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_frame(wsr_pkg::OP_PING, 64'd1, ENC_DIRECT, 1'b0);  // pong owed
    send_byte({4'h0, OP_TEXT});                              // fragmented text start
    send_byte(8'h01);
    send_byte(8'h00);
    send_frame(OP_PONG, 64'd0, ENC_DIRECT, 1'b0);           // empty control frame in between
    send_frame(wsr_pkg::OP_CONT, 64'd1, ENC_DIRECT, 1'b0);
    send_frame(wsr_pkg::OP_BINARY, 64'd1, ENC_EXT64, 1'b0);
  endtask

  // Random traffic under each idling mix, closes held back
  task automatic test_random_frames();
    src_idle_pct = 0;  sink_stall_pct = 0;  random_frames(280, 1'b0);
    src_idle_pct = 88; sink_stall_pct = 0;  random_frames(280, 1'b0);
    src_idle_pct = 0;  sink_stall_pct = 88; random_frames(280, 1'b0);
    src_idle_pct = 13; sink_stall_pct = 13; random_frames(280, 1'b0);
  endtask

  // Close request, then suppression of every later reply
  task automatic test_close_handling();
    src_idle_pct = 13;
    sink_stall_pct = 13;
    send_frame(wsr_pkg::OP_CLOSE, 64'd1, ENC_DIRECT, 1'b0);
    send_frame(wsr_pkg::OP_CLOSE, 64'd0, ENC_DIRECT, 1'b0);
    send_frame(wsr_pkg::OP_PING, 64'd0, ENC_DIRECT, 1'b0);
    send_frame(wsr_pkg::OP_PING, 64'd1, ENC_DIRECT, 1'b0);
    random_frames(180, 1'b1);
  endtask

  // Masked frame with a huge length: sticky error from the last header byte on
  task automatic test_masked_frame();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_frame(wsr_pkg::OP_BINARY, '1, ENC_EXT64, 1'b1);
    repeat (8) send_byte(8'($urandom_range(255)));
  endtask

  // Result sink stalls
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
    mismatches++;
  endtask

  // Compare each result transaction with the oldest classification owed
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) report_mismatch("kind", want.kind, m_axis_tuser);
        if (m_axis_tdata[7:0] !== want.out_byte)
          report_mismatch("out_byte", want.out_byte, m_axis_tdata[7:0]);
        if (m_axis_tdata[11:8] !== want.effective_opcode)
          report_mismatch("effective_opcode", want.effective_opcode, m_axis_tdata[11:8]);
        if (m_axis_tdata[13:12] !== want.reply)
          report_mismatch("reply", want.reply, m_axis_tdata[13:12]);
        if (m_axis_tdata[15:14] !== 2'b00)
          report_mismatch("tdata padding", 0, m_axis_tdata[15:14]);
        if (m_axis_tlast !== want.frame_end)
          report_mismatch("frame_end", want.frame_end, m_axis_tlast);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_random_frames();
    test_close_handling();
    test_masked_frame();
    s_axis_tvalid <= 1'b0;
    // Drain, then wait for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
